// File: hdl/frame_group_averager_assert.svh
// assertion macros for the frame group averager
`ifndef FRAME_GROUP_AVERAGER_ASSERT_SVH
`define FRAME_GROUP_AVERAGER_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, idle while reset is high
`define FGA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also evaluated during reset
`define FGA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FGA_ASSERT(name, prop, msg)
`define FGA_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// File: hdl/fga_pkg.sv
// shared types and constants of the frame group averager
package fga_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 24;
  localparam int FRAC_W    = 8;
  localparam int MEAN_W    = 24;
  localparam int N_W       = 9;
  localparam int PPF_W     = 17;
  localparam int CMP_W     = 25;
  localparam int DIVD_W    = ACC_W + FRAC_W;
  localparam int DIV_DIGIT = 4;
  localparam int DIV_ITERS = DIVD_W / DIV_DIGIT;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

  // register indexes on the config port
  localparam logic REG_FRAMES = 1'b0;
  localparam logic REG_PIXELS = 1'b1;

  localparam logic [N_W-1:0]   FRAMES_RESET = 9'd1;
  localparam logic [PPF_W-1:0] PIXELS_RESET = 17'h10000;

  typedef struct packed {
    logic [N_W-1:0]   frames_to_average;
    logic [PPF_W-1:0] pixels_per_frame;
  } fga_cfg_t;

endpackage

// File: hdl/frame_group_averager.sv
// frame group averager top level: sequencer, frame counters, output register
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid / s_tready  s_tdata[15:0] sample
//   m_*       out   m_tvalid / m_tready  m_tdata[23:0] mean, m_tlast frame_end
//   apb       in    psel / penable       paddr, pwdata, prdata (pready tied high)
//
// an item that yields no result is accepted with an accumulator read, then
// its entry gets a read-modify-write; a pass-through item has its result formed
// in the calc state, with no write; an item of a group's last frame gets the
// read-modify-write and then the radix-16 divider that forms sum * 256 / n
// reset is synchronous and clears the sequencer, counters and output valid;
// the accumulator memory is not cleared, the first frame of a group overwrites
// a full output register stalls the sequencer only when a new result is due

`include "frame_group_averager_assert.svh"

module frame_group_averager
  import fga_pkg::*;
#(
  parameter int FRAME_DEPTH = 65536,
  parameter int MAX_GROUP   = 256
) (
  input  logic                clk,
  input  logic                rst,
  // sample stream in
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,    // [15:0] sample
  // averaged stream out
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [MEAN_W-1:0]   m_tdata,    // [23:0] mean
  output logic                m_tlast,    // frame_end
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int PW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int GW = $clog2(MAX_GROUP);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  fga_cfg_t cfg;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [PW-1:0] pixel_position;
  logic [GW-1:0] frame_in_group;

  // context of the item in flight
  logic [SAMPLE_W-1:0] smp;
  logic [PW-1:0]       addr;
  logic [N_W-1:0]      n_q;
  logic                lp_q;
  logic                emit_q;
  logic                first_q;
  logic                pass_q;

  // result parked while the output register is full
  logic [MEAN_W-1:0] hold_mean;
  logic              hold_last;

  logic              accept;
  logic [N_W-1:0]    n_eff;
  logic [PPF_W-1:0]  ppf_eff;
  logic [PPF_W-1:0]  last_idx;
  logic [PW-1:0]     pos_clamp;
  logic              last_pixel;
  logic              last_frame;
  logic              pass;

  logic [ACC_W-1:0]  mem_rd;
  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  acc_new;
  logic              mem_wr;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;

  logic              res_valid;
  logic [MEAN_W-1:0] res_mean;
  logic              res_last;
  logic              out_free;
  logic              load;

  fga_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // effective group size and frame size after clamping
  always_comb begin
    if (CMP_W'(cfg.frames_to_average) > CMP_W'(MAX_GROUP)) begin
      n_eff = N_W'(MAX_GROUP);
    end else begin
      n_eff = cfg.frames_to_average;
    end
    if (cfg.pixels_per_frame == '0) begin
      ppf_eff = PPF_W'(1);
    end else if (CMP_W'(cfg.pixels_per_frame) > CMP_W'(FRAME_DEPTH)) begin
      ppf_eff = PPF_W'(FRAME_DEPTH);
    end else begin
      ppf_eff = cfg.pixels_per_frame;
    end
  end

  assign last_idx   = ppf_eff - 1'b1;
  assign last_pixel = CMP_W'(pixel_position) >= CMP_W'(last_idx);
  // a shrunk frame ends at the current pixel
  assign pos_clamp  = last_pixel ? PW'(last_idx) : pixel_position;
  assign pass       = n_eff <= N_W'(1);
  // n - 1 only matters outside pass-through, where n is at least two
  assign last_frame = CMP_W'(frame_in_group) >= CMP_W'(n_eff - 1'b1);

  assign s_tready = state == ST_IDLE;
  assign accept   = s_tvalid && s_tready;

  // frame counters advance as the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      frame_in_group <= '0;
    end else if (accept) begin
      pixel_position <= last_pixel ? '0 : pos_clamp + 1'b1;
      if (pass) begin
        frame_in_group <= '0;
      end else if (last_pixel) begin
        frame_in_group <= last_frame ? '0 : frame_in_group + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp     <= s_tdata;
      addr    <= pos_clamp;
      n_q     <= n_eff;
      lp_q    <= last_pixel;
      pass_q  <= pass;
      emit_q  <= pass || last_frame;
      first_q <= frame_in_group == '0;
    end
  end

  // entry is read on accept and written back in the calc cycle; the next
  // read is issued no earlier than the cycle after, so no forwarding is needed
  fga_acc_mem #(
    .DEPTH (FRAME_DEPTH),
    .AW    (PW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (pos_clamp),
    .rd_data (mem_rd),
    .wr_en   (mem_wr),
    .wr_addr (addr),
    .wr_data (acc_new)
  );

  // first frame overwrites, later frames add with saturation
  assign sum     = {1'b0, mem_rd} + (ACC_W+1)'(smp);
  assign acc_new = first_q ? ACC_W'(smp) : (sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0]);
  assign mem_wr  = (state == ST_CALC) && !pass_q;

  assign div_start = (state == ST_CALC) && emit_q && !pass_q;

  fga_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({acc_new, {FRAC_W{1'b0}}}),
    .divisor  (n_q),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // pick the result that is due this cycle
  always_comb begin
    res_valid = 1'b0;
    res_mean  = hold_mean;
    res_last  = lp_q;
    case (state)
      ST_CALC: begin
        res_valid = emit_q && pass_q;
        res_mean  = {smp, {FRAC_W{1'b0}}};
      end
      ST_DIV: begin
        res_valid = div_done;
        res_mean  = (|div_quo[DIVD_W-1:MEAN_W]) ? MEAN_MAX : div_quo[MEAN_W-1:0];
      end
      ST_HOLD: begin
        res_valid = 1'b1;
        res_mean  = hold_mean;
        res_last  = hold_last;
      end
      default: res_valid = 1'b0;
    endcase
  end

  assign out_free = !m_tvalid || m_tready;
  assign load     = res_valid && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_CALC;
      ST_CALC: begin
        if (!emit_q) begin
          state_next = ST_IDLE;
        end else if (!pass_q) begin
          state_next = ST_DIV;
        end else begin
          state_next = load ? ST_IDLE : ST_HOLD;
        end
      end
      ST_DIV: if (div_done) state_next = load ? ST_IDLE : ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && !out_free && state != ST_HOLD) begin
      hold_mean <= res_mean;
      hold_last <= res_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= res_mean;
      m_tlast <= res_last;
    end
  end

  `FGA_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE) && !m_tvalid, "reset left block busy")
  `FGA_ASSERT(a_ready_div_idle, s_tready |-> !div_busy, "item taken while divider busy")
  `FGA_ASSERT(a_done_in_div, div_done |-> (state == ST_DIV), "divider result outside div state")
  `FGA_ASSERT(a_frame_wrap, (accept && last_pixel) |=> (pixel_position == '0), "frame did not wrap")
  `FGA_ASSERT(a_pass_group, (accept && pass) |=> (frame_in_group == '0), "group count in pass-through")

endmodule

// File: hdl/fga_cfg.sv
// config register bank behind the apb-style port
module fga_cfg
  import fga_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output fga_cfg_t    cfg
);

  logic [N_W-1:0]   frames_to_average;
  logic [PPF_W-1:0] pixels_per_frame;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_to_average <= FRAMES_RESET;
      pixels_per_frame  <= PIXELS_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_FRAMES: frames_to_average <= pwdata[N_W-1:0];
        REG_PIXELS: pixels_per_frame  <= pwdata[PPF_W-1:0];
        default: ;
      endcase
    end
  end

  // unaligned reads return zero
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        REG_FRAMES: prdata = {{(32-N_W){1'b0}}, frames_to_average};
        REG_PIXELS: prdata = {{(32-PPF_W){1'b0}}, pixels_per_frame};
        default:    prdata = '0;
      endcase
    end
  end

  assign cfg.frames_to_average = frames_to_average;
  assign cfg.pixels_per_frame  = pixels_per_frame;

endmodule

// File: hdl/fga_acc_mem.sv
// accumulator memory, one write and one registered read port
module fga_acc_mem
  import fga_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [ACC_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ACC_W-1:0] wr_data
);

  logic [ACC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/fga_div.sv
// iterative radix-16 restoring divider, four quotient bits a cycle
module fga_div
  import fga_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [N_W-1:0]    divisor,
  output logic              busy,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVD_W-1:0]    dvd;
  logic [N_W-1:0]       dsr;
  logic [N_W-1:0]       rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [N_W-1:0]       rem_next;
  logic [DIV_DIGIT-1:0] qdigit;

  // one radix-16 digit: four compare-subtract steps on a narrow remainder
  always_comb begin
    logic [N_W:0] trial;
    rem_next = rem;
    qdigit   = '0;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      trial = {rem_next, dvd[DIVD_W-1-i]};
      if (trial >= {1'b0, dsr}) begin
        trial = trial - {1'b0, dsr};
        qdigit[DIV_DIGIT-1-i] = 1'b1;
      end
      rem_next = trial[N_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DIVD_W-DIV_DIGIT-1:0], {DIV_DIGIT{1'b0}}};
      rem      <= rem_next;
      quotient <= {quotient[DIVD_W-DIV_DIGIT-1:0], qdigit};
    end
  end

endmodule
